// File: rtl/core/glu_pkg.sv
// Shared constants and types for the GCD / LCM unit.
`default_nettype none
package glu_pkg;

   localparam int VALUE_BITS = 31;
   localparam int MULT_BITS  = 2 * VALUE_BITS;
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

   // Completion report from an iterative unit back to the sequencer.
   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] value;
   } unit_rsp_type;

endpackage
`default_nettype wire

// File: rtl/core/glu_gcd.sv
// Binary GCD engine: one compare/subtract or shift per cycle, operands non-zero.
`default_nettype none
module glu_gcd
   import glu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] first,
   input  wire logic [VALUE_BITS-1:0] second,
   output      unit_rsp_type          rsp
);

   logic                  busy_ff,  busy_in;
   logic                  done_ff,  done_in;
   logic [VALUE_BITS-1:0] u_ff,     u_in;
   logic [VALUE_BITS-1:0] v_ff,     v_in;
   logic [CNT_BITS-1:0]   shift_ff, shift_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      u_in     = u_ff;
      v_in     = v_ff;
      shift_in = shift_ff;
      value_in = value_ff;
      if (start) begin
         busy_in  = 1'b1;
         u_in     = first;
         v_in     = second;
         shift_in = '0;
      end else if (busy_ff) begin
         priority if (u_ff == v_ff) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            value_in = u_ff << shift_ff;
         end else if (!u_ff[0] && !v_ff[0]) begin
            // common factor of two, restored at the end
            u_in     = u_ff >> 1;
            v_in     = v_ff >> 1;
            shift_in = shift_ff + CNT_BITS'(1);
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff > v_ff) begin
            u_in = u_ff - v_ff;
         end else begin
            v_in = v_ff - u_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      u_ff     <= u_in;
      v_ff     <= v_in;
      shift_ff <= shift_in;
      value_ff <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule
`default_nettype wire

// File: rtl/core/glu_div.sv
// Restoring divider: one quotient bit per cycle, divisor non-zero.
`default_nettype none
module glu_div
   import glu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [VALUE_BITS-1:0] divisor,
   output      unit_rsp_type          rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff,  cnt_in;
   logic [VALUE_BITS-1:0] rem_ff,  rem_in;
   logic [VALUE_BITS-1:0] quo_ff,  quo_in;
   logic [VALUE_BITS-1:0] dsr_ff,  dsr_in;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;

   // quo_ff shifts the dividend out at the top and the quotient in at the bottom
   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(VALUE_BITS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[VALUE_BITS]) begin
            rem_in = diff[VALUE_BITS-1:0];
            quo_in = {quo_ff[VALUE_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[VALUE_BITS-1:0];
            quo_in = {quo_ff[VALUE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = quo_ff;

endmodule
`default_nettype wire

// File: rtl/core/gcd_lcm_unit.sv
// Top level: sequencer, product stage and result register of the GCD / LCM unit.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_first_value, req_second_value
//   rsp      out        rsp_valid/rsp_stall   rsp_divisor, rsp_multiple,
//                                             rsp_both_zero_error
//
// One transaction at a time; req_stall is high from acceptance until the result
// moves into the output register. A zero operand goes straight to ST_DONE;
// otherwise the binary GCD loop runs, then the divider, the product stage and
// the hand-over into the output register.
// A held result in the output register does not block the next request.
// Synchronous active-high reset clears the sequencer and valid flags only.
`default_nettype none
module gcd_lcm_unit
   import glu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [VALUE_BITS-1:0] req_first_value,
   input  wire logic [VALUE_BITS-1:0] req_second_value,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [VALUE_BITS-1:0] rsp_divisor,
   output      logic [MULT_BITS-1:0]  rsp_multiple,
   output      logic                  rsp_both_zero_error
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_GCD  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] op_a_ff,  op_a_in;
   logic [VALUE_BITS-1:0] op_b_ff,  op_b_in;
   logic [VALUE_BITS-1:0] res_div_ff, res_div_in;
   logic [VALUE_BITS-1:0] quo_ff,   quo_in;
   logic [MULT_BITS-1:0]  res_mul_ff, res_mul_in;
   logic                  res_err_ff, res_err_in;
   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0] out_div_ff, out_div_in;
   logic [MULT_BITS-1:0]  out_mul_ff, out_mul_in;
   logic                  out_err_ff, out_err_in;
   logic                  req_accept;
   logic                  any_zero;
   logic                  gcd_start;
   logic                  div_start;
   logic                  out_load;
   unit_rsp_type          gcd_rsp;
   unit_rsp_type          div_rsp;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign any_zero   = (req_first_value == '0) || (req_second_value == '0);
   assign gcd_start  = req_accept && !any_zero;
   assign div_start  = (state_ff == ST_GCD) && gcd_rsp.done;
   assign out_load   = (state_ff == ST_DONE) && (!out_valid_ff || !rsp_stall);

   glu_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .first  (req_first_value),
      .second (req_second_value),
      .rsp    (gcd_rsp)
   );

   // lcm = (a / gcd) * b keeps every intermediate within the operand width
   glu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (op_a_ff),
      .divisor  (gcd_rsp.value),
      .rsp      (div_rsp)
   );

   always_comb begin
      state_in   = state_ff;
      op_a_in    = op_a_ff;
      op_b_in    = op_b_ff;
      res_div_in = res_div_ff;
      quo_in     = quo_ff;
      res_mul_in = res_mul_ff;
      res_err_in = res_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_a_in = req_first_value;
               op_b_in = req_second_value;
               if (any_zero) begin
                  res_div_in = req_first_value | req_second_value;
                  res_mul_in = '0;
                  res_err_in = (req_first_value == '0) && (req_second_value == '0);
                  state_in   = ST_DONE;
               end else begin
                  res_err_in = 1'b0;
                  state_in   = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (gcd_rsp.done) begin
               res_div_in = gcd_rsp.value;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               quo_in   = div_rsp.value;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            res_mul_in = MULT_BITS'(quo_ff) * MULT_BITS'(op_b_ff);
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_div_in   = out_div_ff;
      out_mul_in   = out_mul_ff;
      out_err_in   = out_err_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_div_in   = res_div_ff;
         out_mul_in   = res_mul_ff;
         out_err_in   = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      op_a_ff    <= op_a_in;
      op_b_ff    <= op_b_in;
      res_div_ff <= res_div_in;
      quo_ff     <= quo_in;
      res_mul_ff <= res_mul_in;
      res_err_ff <= res_err_in;
      out_div_ff <= out_div_in;
      out_mul_ff <= out_mul_in;
      out_err_ff <= out_err_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_divisor         = out_div_ff;
   assign rsp_multiple        = out_mul_ff;
   assign rsp_both_zero_error = out_err_ff;

endmodule
`default_nettype wire

// File: rtl/core/glu_checker.sv
// Port-level checks for the GCD / LCM unit, bound to the top level.
`default_nettype none
module glu_checker
   import glu_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [VALUE_BITS-1:0] rsp_divisor,
   input wire logic [MULT_BITS-1:0]  rsp_multiple,
   input wire logic                  rsp_both_zero_error
);

   // error flag only with an all-zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_both_zero_error |-> (rsp_divisor == '0) && (rsp_multiple == '0))
      else $error("error flag with non-zero result");

   // a valid result without the error flag always has a non-zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_both_zero_error |-> (rsp_divisor != '0))
      else $error("zero divisor without error flag");

   // the multiple is either zero or at least the divisor
   a_mul_ge_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_multiple != '0) |-> (rsp_multiple >= MULT_BITS'(rsp_divisor)))
      else $error("multiple below divisor");

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_divisor)
         && $stable(rsp_multiple) && $stable(rsp_both_zero_error))
      else $error("stalled result changed");

   // nothing pending straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind gcd_lcm_unit glu_checker u_glu_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_divisor         (rsp_divisor),
   .rsp_multiple        (rsp_multiple),
   .rsp_both_zero_error (rsp_both_zero_error)
);
`default_nettype wire
